[rtl/core/trd_pkg.sv]
// Shared types and constants for the run-length pixel decoder.
// No dependencies; imported by tga_rle_pixel_decoder_core and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package trd_pkg;

    // Packet header layout
    localparam int unsigned HDR_REPEAT_BIT = 7;
    localparam logic [6:0]  HDR_COUNT_MASK = 7'h7F;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_PIXEL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_TOTAL     = 1'b1;

    // Register reset values
    localparam logic [2:0]  BPP_RESET         = 3'd3;
    localparam logic [31:0] PIXEL_TOTAL_RESET = 32'd1;

    localparam logic [2:0]  BPP_MIN = 3'd1;
    localparam logic [2:0]  BPP_MAX = 3'd4;

    // Stream widths
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 40;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  run_count;
        logic        image_done;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/tga_rle_pixel_decoder_core.sv]
// Run-length pixel decoder top level: byte stream in, pixel runs out.
// Depends on trd_pkg for register indexes, header constants and the result type.
`timescale 1ns / 1ps
`default_nettype none

// Takes one coded byte per clock and can keep doing so indefinitely as long as
// the result side keeps up. A header byte or an inner pixel byte produces no
// result; the byte that completes a pixel produces one run, which appears on
// the master side in the cycle after that byte is taken. The single result
// register sets the rate: a new byte is taken whenever that register is empty
// or is being emptied in the same cycle. m_tdata carries pixel_value in bits
// 31:0 and run_count in bits 39:32; m_tlast is image_done. Register writes take
// effect on the next byte; write only between transactions.
module tga_rle_pixel_decoder_core
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [trd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [trd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // coded byte stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [trd_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] stream_byte
    // pixel runs
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [trd_pkg::OUT_DATA_W-1:0]          m_tdata,   // [31:0] pixel_value,
                                                               // [39:32] run_count
    output logic                                    m_tlast    // image_done
);

    import trd_pkg::*;

    // Configuration registers
    logic [2:0]  bpp_reg;
    logic [31:0] pixel_total_reg;

    // Decoder state
    logic        expect_header_reg, expect_header_next;
    logic        repeat_packet_reg, repeat_packet_next;
    logic [7:0]  packet_left_reg,   packet_left_next;
    logic [1:0]  byte_position_reg, byte_position_next;
    logic [31:0] pixel_acc_reg,     pixel_acc_next;
    logic [31:0] pixels_done_reg,   pixels_done_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    result_t     result_reg,    result_next;

    logic        s_fire;
    logic        produce;
    logic [2:0]  bpp_eff;
    logic [31:0] acc_merged;
    logic        pixel_last;
    logic [31:0] remaining;
    logic [7:0]  run_count;
    logic        done;
    logic [7:0]  left_after;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        if (bpp_reg == 3'd0)
            bpp_eff = BPP_MIN;
        else if (bpp_reg > BPP_MAX)
            bpp_eff = BPP_MAX;
        else
            bpp_eff = bpp_reg;
    end

    assign acc_merged = pixel_acc_reg
                      | ({24'd0, s_tdata} << {byte_position_reg, 3'b000});
    assign pixel_last = (({1'b0, byte_position_reg} + 3'd1) >= bpp_eff);
    assign remaining  = (pixel_total_reg > pixels_done_reg)
                      ? (pixel_total_reg - pixels_done_reg) : 32'd1;

    always_comb
    begin
        if (!repeat_packet_reg || packet_left_reg == 8'd0)
            run_count = 8'd1;
        else if ({24'd0, packet_left_reg} < remaining)
            run_count = packet_left_reg;
        else
            run_count = remaining[7:0];   // at most 128 here
    end

    assign done = ({24'd0, run_count} >= remaining);

    always_comb
    begin
        if (repeat_packet_reg || packet_left_reg == 8'd0)
            left_after = 8'd0;
        else
            left_after = packet_left_reg - 8'd1;
    end

    assign produce = s_fire && !expect_header_reg && pixel_last;

    always_comb
    begin
        expect_header_next = expect_header_reg;
        repeat_packet_next = repeat_packet_reg;
        packet_left_next   = packet_left_reg;
        byte_position_next = byte_position_reg;
        pixel_acc_next     = pixel_acc_reg;
        pixels_done_next   = pixels_done_reg;

        if (s_fire)
        begin
            priority if (expect_header_reg)
            begin
                repeat_packet_next = s_tdata[HDR_REPEAT_BIT];
                packet_left_next   = {1'b0, s_tdata[6:0] & HDR_COUNT_MASK} + 8'd1;
                byte_position_next = 2'd0;
                pixel_acc_next     = 32'd0;
                expect_header_next = 1'b0;
            end
            else if (!pixel_last)
            begin
                pixel_acc_next     = acc_merged;
                byte_position_next = byte_position_reg + 2'd1;
            end
            else
            begin
                pixel_acc_next     = 32'd0;
                byte_position_next = 2'd0;
                if (done)
                begin
                    // drop whatever is left of the packet
                    pixels_done_next   = 32'd0;
                    packet_left_next   = 8'd0;
                    expect_header_next = 1'b1;
                end
                else
                begin
                    pixels_done_next   = pixels_done_reg + {24'd0, run_count};
                    packet_left_next   = left_after;
                    expect_header_next = (left_after == 8'd0);
                end
            end
        end
    end

    always_comb
    begin
        result_next.pixel_value = acc_merged;
        result_next.run_count   = run_count;
        result_next.image_done  = done;
    end

    always_comb
    begin
        if (produce)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg           <= BPP_RESET;
            pixel_total_reg   <= PIXEL_TOTAL_RESET;
            expect_header_reg <= 1'b1;
            repeat_packet_reg <= 1'b0;
            packet_left_reg   <= 8'd0;
            byte_position_reg <= 2'd0;
            pixel_acc_reg     <= 32'd0;
            pixels_done_reg   <= 32'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BYTES_PER_PIXEL: bpp_reg         <= cfg_data[2:0];
                    CFG_PIXEL_TOTAL:     pixel_total_reg <= cfg_data;
                    default:             ;
                endcase
            end
            expect_header_reg <= expect_header_next;
            repeat_packet_reg <= repeat_packet_next;
            packet_left_reg   <= packet_left_next;
            byte_position_reg <= byte_position_next;
            pixel_acc_reg     <= pixel_acc_next;
            pixels_done_reg   <= pixels_done_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload holds while stalled; load only on a new result
    always_ff @(posedge clk)
    begin
        if (produce)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.run_count, result_reg.pixel_value};
    assign m_tlast  = result_reg.image_done;

    // A packet in progress always has pixels left to deliver
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !expect_header_reg |-> packet_left_reg != 8'd0)
        else $error("packet in progress with no pixels left");

    // Completing the image returns the decoder to header hunting
    a_done_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && done) |=> (expect_header_reg && pixels_done_reg == 32'd0))
        else $error("image completed but decoder not reset to header");

    // A delivered run always covers at least one pixel
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> result_reg.run_count != 8'd0)
        else $error("run with zero count");

    // A header byte never creates a result
    a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && expect_header_reg && (!out_valid_reg || m_tready)) |=> !out_valid_reg)
        else $error("header byte produced a result");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for tga_rle_pixel_decoder_core: coded bytes in, pixel runs out.
// It predicts each run from a local copy of the decoder state and checks it against the block.
// Depends on trd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module testbench;
    import trd_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES  = 1650;
    localparam int MAX_REPORTS   = 10;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_PERIODIC} rx_mode_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;   // [7:0] stream_byte
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;          // [31:0] pixel_value, [39:32] run_count
    logic                   m_tlast;          // image_done

    // Decoder state mirror and register copies
    logic        want_header     = 1'b1;
    logic        in_repeat       = 1'b0;
    logic [7:0]  pkt_pixels_left = 8'd0;
    logic [1:0]  byte_slot       = 2'd0;
    logic [31:0] pixel_acc       = 32'd0;
    logic [31:0] image_pixels    = 32'd0;
    logic [2:0]  reg_bpp         = BPP_RESET;
    logic [31:0] reg_total       = PIXEL_TOTAL_RESET;

    result_t pending_runs[$];
    int      mismatches  = 0;
    int      idle_cycles = 0;
    int      burst_left  = 0;
    int      bytes_sent  = 0;
    bit      hold_request = 1'b0;

    always #5 clk = ~clk;

    tga_rle_pixel_decoder_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endfunction

    function automatic logic [7:0] packet_header(input bit is_run, input int pixels);
        packet_header = {is_run, 7'(pixels - 1) & HDR_COUNT_MASK};
    endfunction

    // Advance the decoder mirror by one coded byte; queue the run it completes.
    task automatic decode_stream_byte(input logic [7:0] b);
        logic [2:0]  bpp;
        logic [31:0] left_in_image;
        logic [7:0]  run;
        logic        done;
        result_t     run_item;
        bpp = (reg_bpp < BPP_MIN) ? BPP_MIN : (reg_bpp > BPP_MAX) ? BPP_MAX : reg_bpp;
        if (want_header)
        begin
            in_repeat       = b[HDR_REPEAT_BIT];
            pkt_pixels_left = 8'(b[6:0] & HDR_COUNT_MASK) + 8'd1;
            byte_slot       = 2'd0;
            pixel_acc       = 32'd0;
            want_header     = 1'b0;
        end
        else
        begin
            pixel_acc |= 32'(b) << (8 * byte_slot);
            if (3'(byte_slot) + 3'd1 < bpp)
            begin
                byte_slot++;
            end
            else
            begin
                // zero or already reached total: the next pixel closes the image
                left_in_image = (reg_total > image_pixels) ? reg_total - image_pixels : 32'd1;
                if (in_repeat)
                begin
                    run = (32'(pkt_pixels_left) < left_in_image) ? pkt_pixels_left
                                                                 : left_in_image[7:0];
                    pkt_pixels_left = 8'd0;
                end
                else
                begin
                    run = 8'd1;
                    if (pkt_pixels_left != 8'd0)
                    begin
                        pkt_pixels_left--;
                    end
                end
                if (run == 8'd0)
                begin
                    run = 8'd1;
                end
                done = (32'(run) >= left_in_image);
                run_item.pixel_value = pixel_acc;
                run_item.run_count   = run;
                run_item.image_done  = done;
                pending_runs.push_back(run_item);
                pixel_acc = 32'd0;
                byte_slot = 2'd0;
                if (done)
                begin
                    // drop whatever is left of the packet
                    image_pixels    = 32'd0;
                    pkt_pixels_left = 8'd0;
                    want_header     = 1'b1;
                end
                else
                begin
                    image_pixels += 32'(run);
                    if (pkt_pixels_left == 8'd0)
                    begin
                        want_header = 1'b1;
                    end
                end
            end
        end
    endtask

    // Sample every transaction at the rising edge: register writes, runs, bytes.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            want_header     = 1'b1;
            in_repeat       = 1'b0;
            pkt_pixels_left = 8'd0;
            byte_slot       = 2'd0;
            pixel_acc       = 32'd0;
            image_pixels    = 32'd0;
            reg_bpp         = BPP_RESET;
            reg_total       = PIXEL_TOTAL_RESET;
            idle_cycles     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BYTES_PER_PIXEL)
                begin
                    reg_bpp = cfg_data[2:0];
                end
                else if (cfg_index == CFG_PIXEL_TOTAL)
                begin
                    reg_total = cfg_data;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_runs.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected run: value %h count %0d last %b",
                                            m_tdata[31:0], m_tdata[39:32], m_tlast));
                end
                else
                begin
                    want = pending_runs.pop_front();
                    if (m_tdata[31:0] !== want.pixel_value || m_tdata[39:32] !== want.run_count
                        || m_tlast !== want.image_done)
                    begin
                        note_mismatch($sformatf(
                            "expected value %h count %0d last %b, got value %h count %0d last %b",
                            want.pixel_value, want.run_count, want.image_done,
                            m_tdata[31:0], m_tdata[39:32], m_tlast));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_stream_byte(s_tdata);
            end
            if (cfg_we || (m_tvalid && m_tready) || (s_tvalid && s_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Result side: switch between stall patterns, with a long hold-off on request.
    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        logic     rdy;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 200);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS: rdy = 1'b1;
                    RX_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
                    RX_SELDOM: rdy = ($urandom_range(0, 3) == 0);
                    default:   rdy = ((tick % 7) < 3);
                endcase
            end
            m_tready <= rdy;
        end
    end

    // Offer one byte in bursts with random gaps; return at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        bytes_sent++;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Stop sending and let every expected run drain.
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_runs.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_format(input logic [2:0] bpp, input logic [31:0] total);
        write_reg(CFG_BYTES_PER_PIXEL, 32'(bpp));
        write_reg(CFG_PIXEL_TOTAL, total);
    endtask

    // Well-formed stream with random content: headers where the decoder expects one,
    // with a little noise mixed in.
    task automatic send_coded_bytes(input int count);
        logic [7:0] b;
        int         pixels;
        repeat (count)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                b = 8'($urandom_range(0, 255));
            end
            else if (want_header)
            begin
                pixels = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128)
                                                     : $urandom_range(1, 8);
                b = packet_header(1'($urandom_range(0, 1)), pixels);
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
            end
            send_byte(b);
        end
    endtask

    task automatic test_reset_values();
        // three bytes per pixel, one pixel per image
        send_byte(packet_header(1'b0, 1));
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        wait_idle();
    endtask

    task automatic test_pixel_widths();
        set_format(3'd4, 32'd300);
        send_byte(packet_header(1'b1, 128));
        repeat (4) send_byte(8'hFF);
        wait_idle();
        // zero acts as one byte per pixel
        write_reg(CFG_BYTES_PER_PIXEL, 32'd0);
        send_byte(packet_header(1'b0, 2));
        send_byte(8'h00);
        send_byte(8'h80);
        wait_idle();
        // above four saturates to four
        write_reg(CFG_BYTES_PER_PIXEL, 32'd7);
        send_byte(packet_header(1'b1, 6));
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_byte(8'h3C);
        send_byte(8'hC3);
        wait_idle();
    endtask

    task automatic test_image_limits();
        set_format(3'd1, 32'd3);
        // repeat count cut at the image end
        send_byte(packet_header(1'b1, 5));
        send_byte(8'h5A);
        // raw packet runs past the image end; its unread pixel is dropped
        send_byte(packet_header(1'b0, 4));
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        wait_idle();
        write_reg(CFG_PIXEL_TOTAL, 32'd0);
        send_byte(packet_header(1'b0, 1));
        send_byte(8'h99);
        wait_idle();
        // total lowered below the pixels already emitted
        write_reg(CFG_PIXEL_TOTAL, 32'd10);
        send_byte(packet_header(1'b1, 5));
        send_byte(8'h11);
        wait_idle();
        write_reg(CFG_PIXEL_TOTAL, 32'd4);
        send_byte(packet_header(1'b0, 1));
        send_byte(8'h22);
        wait_idle();
    endtask

    task automatic test_random_images();
        int          phase;
        logic [2:0]  bpp;
        logic [31:0] total;
        phase = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            bpp = (phase == 0) ? 3'd1 : (phase == 1) ? 3'd4 : 3'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0:       total = 32'd0;
                1:       total = 32'hFFFF_FFFF;
                2:       total = $urandom();
                default: total = $urandom_range(1, 400);
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_BYTES_PER_PIXEL, 32'(bpp));
                1:       write_reg(CFG_PIXEL_TOTAL, total);
                default: set_format(bpp, total);
            endcase
            send_coded_bytes($urandom_range(60, 200));
            wait_idle();
            phase++;
        end
    endtask

    task automatic test_output_stall();
        // fill the result register and stall the byte side
        set_format(3'd1, 32'd50);
        hold_request = 1'b1;
        send_coded_bytes(60);
        wait_idle();
    endtask

    task automatic test_sender_pause();
        set_format(3'd2, 32'd40);
        send_coded_bytes(30);
        wait_idle();
        send_coded_bytes(30);
        wait_idle();
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_values();
        test_pixel_widths();
        test_image_limits();
        test_random_images();
        test_output_stall();
        test_sender_pause();
        wait_idle();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending_runs.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/trd_pkg.sv
rtl/core/tga_rle_pixel_decoder_core.sv
tb/testbench.sv
